@@ design/v4dmn_pkg.sv @@
// ----------------------------------------------------------------------------
// v4dmn_pkg: shared types and constants for the 4-vector dot/length unit
// Operation codes and field widths.
// ----------------------------------------------------------------------------
package v4dmn_pkg;

  localparam int CompWidthDef = 16;
  localparam int ScalarBits   = 34;
  localparam int NormBits     = 16;
  localparam int NormFrac     = 14;

  typedef enum logic [1:0] {
    OP_DOT  = 2'd0,
    OP_SQR  = 2'd1,
    OP_LEN  = 2'd2,
    OP_NORM = 2'd3
  } op_t;

endpackage

@@ design/v4dmn_sqrt.sv @@
// ----------------------------------------------------------------------------
// v4dmn_sqrt: pipelined rounded integer square root
// One result bit per stage, restoring method, round to nearest at the end.
// Sideband data of type SB_T rides along with each item.
// ----------------------------------------------------------------------------
module v4dmn_sqrt #(
  parameter int IN_W  = 36,
  parameter type SB_T = logic
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [IN_W-1:0] in_rad,
  input  SB_T             in_sb,
  output logic            out_valid,
  output logic [IN_W/2:0] out_root,
  output SB_T             out_sb
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int PW = 2 * RW;

  logic          v_r   [RW+1];
  logic [PW-1:0] rad_r [RW+1];
  logic [RW+1:0] rem_r [RW+1];
  logic [RW-1:0] root_r[RW+1];
  SB_T           sb_r  [RW+1];

  assign v_r[0]    = in_valid;
  assign rad_r[0]  = PW'(in_rad);
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign sb_r[0]   = in_sb;

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic          vs_r;
    logic [PW-1:0] rads_r;
    logic [RW+1:0] rems_r;
    logic [RW-1:0] roots_r;
    SB_T           sbs_r;
    logic [RW+1:0] trial;
    logic [RW+1:0] cand;
    always_comb begin
      trial = {rem_r[s][RW-1:0], rad_r[s][PW-1 -: 2]};
      cand  = {root_r[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r <= 1'b0;
      end else if (en) begin
        vs_r <= v_r[s];
      end
      if (en) begin
        rads_r <= rad_r[s] << 2;
        sbs_r  <= sb_r[s];
        if (trial >= cand) begin
          rems_r  <= trial - cand;
          roots_r <= {root_r[s][RW-2:0], 1'b1};
        end else begin
          rems_r  <= trial;
          roots_r <= {root_r[s][RW-2:0], 1'b0};
        end
      end
    end
    assign v_r[s+1]    = vs_r;
    assign rad_r[s+1]  = rads_r;
    assign rem_r[s+1]  = rems_r;
    assign root_r[s+1] = roots_r;
    assign sb_r[s+1]   = sbs_r;
  end

  // Round to nearest: a remainder above the truncated root rounds up.
  assign out_valid = v_r[RW];
  assign out_sb    = sb_r[RW];
  assign out_root  = (IN_W/2+1)'((rem_r[RW] > (RW+2)'(root_r[RW]))
                     ? {1'b0, root_r[RW]} + 1'b1 : {1'b0, root_r[RW]});
endmodule

@@ design/v4dmn_div.sv @@
// ----------------------------------------------------------------------------
// v4dmn_div: pipelined restoring divider for three normalize quotients
// Computes round(|c| * 2^14 / len) for x, y and z, one quotient bit a stage,
// and applies clamp and sign at the output.
// ----------------------------------------------------------------------------
module v4dmn_div #(
  parameter int CW    = 16,
  parameter int LW    = 9,
  parameter type SB_T = logic
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2:0][CW-1:0]        in_mag,
  input  logic [2:0]                in_neg,
  input  logic [LW-1:0]             in_len,
  input  SB_T                       in_sb,
  output logic                      out_valid,
  output logic [2:0][v4dmn_pkg::NormBits-1:0] out_q,
  output SB_T                       out_sb
);
  import v4dmn_pkg::*;

  // Dividend is mag*2^14 + len/2; quotient width covers mag*2^14 plus one.
  localparam int NW = CW + NormFrac + 1;
  localparam int QW = NW;

  logic                 v_r  [QW+1];
  logic [2:0][NW-1:0]   num_r[QW+1];
  logic [2:0][LW:0]     rem_r[QW+1];
  logic [2:0][QW-1:0]   q_r  [QW+1];
  logic [2:0]           neg_r[QW+1];
  logic [LW-1:0]        den_r[QW+1];
  SB_T                  sb_r [QW+1];

  for (genvar k = 0; k < 3; k++) begin : g_num
    assign num_r[0][k] = (NW'(in_mag[k]) << NormFrac) + NW'(in_len >> 1);
  end
  assign v_r[0]   = in_valid;
  assign rem_r[0] = '0;
  assign q_r[0]   = '0;
  assign neg_r[0] = in_neg;
  assign den_r[0] = in_len;
  assign sb_r[0]  = in_sb;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic               vs_r;
    logic [2:0][NW-1:0] nums_r;
    logic [2:0][LW:0]   rems_r;
    logic [2:0][QW-1:0] qs_r;
    logic [2:0]         negs_r;
    logic [LW-1:0]      dens_r;
    SB_T                sbs_r;
    logic [2:0][LW+1:0] trial;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {rem_r[s][k], num_r[s][k][NW-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r <= 1'b0;
      end else if (en) begin
        vs_r <= v_r[s];
      end
      if (en) begin
        negs_r <= neg_r[s];
        dens_r <= den_r[s];
        sbs_r  <= sb_r[s];
        for (int k = 0; k < 3; k++) begin
          nums_r[k] <= num_r[s][k] << 1;
          if (trial[k] >= (LW+2)'(den_r[s])) begin
            rems_r[k] <= (LW+1)'(trial[k] - (LW+2)'(den_r[s]));
            qs_r[k]   <= {q_r[s][k][QW-2:0], 1'b1};
          end else begin
            rems_r[k] <= (LW+1)'(trial[k]);
            qs_r[k]   <= {q_r[s][k][QW-2:0], 1'b0};
          end
        end
      end
    end
    assign v_r[s+1]   = vs_r;
    assign num_r[s+1] = nums_r;
    assign rem_r[s+1] = rems_r;
    assign q_r[s+1]   = qs_r;
    assign neg_r[s+1] = negs_r;
    assign den_r[s+1] = dens_r;
    assign sb_r[s+1]  = sbs_r;
  end

  // Clamp to one and apply the sign.
  always_comb begin
    logic [QW-1:0] qc;
    for (int k = 0; k < 3; k++) begin
      qc = (q_r[QW][k] > QW'(1 << NormFrac)) ? QW'(1 << NormFrac) : q_r[QW][k];
      out_q[k] = neg_r[QW][k] ? NormBits'(-qc) : NormBits'(qc);
    end
  end
  assign out_valid = v_r[QW];
  assign out_sb    = sb_r[QW];
endmodule

@@ design/vec4_dot_magnitude_normalize.sv @@
// ----------------------------------------------------------------------------
// vec4_dot_magnitude_normalize: fixed-point 4-vector dot, length, normalize
//
//  channel | dir | fields (tdata, lowest bit first)
//  in_     | in  | func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
//  out_    | out | scalar, norm_x, norm_y, norm_z, zero_length
//
// One item per cycle enters and leaves while the output is not stalled. Stages
// at the default width: one for products, one for the sum, one stage per square-root
// bit (17), one stage per quotient bit (31), and an output register.
// A stall holds the whole pipeline. Synchronous active-low reset
// clears the valid bits only.
// ----------------------------------------------------------------------------
module vec4_dot_magnitude_normalize #(
  parameter int COMPONENT_WIDTH = v4dmn_pkg::CompWidthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // func[1:0], a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, zero fill
  input  logic [((2+8*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // scalar[33:0], norm_x, norm_y, norm_z, zero_length, zero fill
  output logic [87:0] out_tdata
);
  import v4dmn_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;
  localparam int LW = SW / 2 + 1;

  typedef struct packed {
    logic [1:0]         op;
    logic [SW-1:0]      sab;
    logic [2:0][CW-1:0] mag;
    logic [2:0]         neg;
  } sq_sb_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [SW-1:0] sab;
    logic [SW-1:0] saa;
    logic [LW-1:0] len;
  } dv_sb_t;

  // Stall: the whole pipe advances when the output register can take data.
  logic en;
  logic out_v_r;
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // Unpack components.
  logic [1:0]                op_in;
  logic signed [3:0][CW-1:0] av, bv;
  always_comb begin
    op_in = in_tdata[1:0];
    for (int k = 0; k < 4; k++) begin
      av[k] = in_tdata[2 + k*CW +: CW];
      bv[k] = in_tdata[2 + (4+k)*CW +: CW];
    end
  end

  // Stage 1: products and component magnitudes.
  logic                 p_v_r;
  logic [1:0]           p_op_r;
  logic signed [PW-1:0] pab_r[4];
  logic signed [PW-1:0] paa_r[4];
  logic [2:0][CW-1:0]   p_mag_r;
  logic [2:0]           p_neg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= in_tvalid;
    end
    if (en) begin
      p_op_r <= op_in;
      for (int k = 0; k < 4; k++) begin
        pab_r[k] <= $signed(av[k]) * $signed(bv[k]);
        paa_r[k] <= $signed(av[k]) * $signed(av[k]);
      end
      for (int k = 0; k < 3; k++) begin
        p_neg_r[k] <= av[k][CW-1];
        p_mag_r[k] <= av[k][CW-1] ? CW'(-av[k]) : CW'(av[k]);
      end
    end
  end

  // Stage 2: sums.
  logic   s_v_r;
  sq_sb_t s_sb_r;
  logic [SW-1:0] s_saa_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= p_v_r;
    end
    if (en) begin
      s_sb_r.op  <= p_op_r;
      s_sb_r.sab <= SW'(pab_r[0]) + SW'(pab_r[1]) + SW'(pab_r[2]) + SW'(pab_r[3]);
      s_saa_r    <= SW'(paa_r[0]) + SW'(paa_r[1]) + SW'(paa_r[2]) + SW'(paa_r[3]);
      s_sb_r.mag <= p_mag_r;
      s_sb_r.neg <= p_neg_r;
    end
  end

  // Square root pipeline; the sum of squares rides along as sideband.
  typedef struct packed {
    sq_sb_t        s;
    logic [SW-1:0] saa;
  } rt_sb_t;
  rt_sb_t rt_in, rt_out;
  logic   rt_v;
  logic [SW/2:0] rt_root;
  assign rt_in = '{s: s_sb_r, saa: s_saa_r};

  v4dmn_sqrt #(.IN_W(SW), .SB_T(rt_sb_t)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s_v_r), .in_rad(s_saa_r), .in_sb(rt_in),
    .out_valid(rt_v), .out_root(rt_root), .out_sb(rt_out)
  );

  // Divider; a zero length is replaced by one and masked at the end.
  dv_sb_t dv_in, dv_out;
  logic   dv_v;
  logic [2:0][NormBits-1:0] dv_q;
  logic [LW-1:0] len_w, den_w;
  assign len_w = LW'(rt_root);
  assign den_w = (len_w == '0) ? LW'(1) : len_w;
  assign dv_in = '{op: rt_out.s.op, sab: rt_out.s.sab, saa: rt_out.saa, len: len_w};

  v4dmn_div #(.CW(CW), .LW(LW), .SB_T(dv_sb_t)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(rt_v), .in_mag(rt_out.s.mag), .in_neg(rt_out.s.neg),
    .in_len(den_w), .in_sb(dv_in),
    .out_valid(dv_v), .out_q(dv_q), .out_sb(dv_out)
  );

  // Result select by operation.
  logic [ScalarBits-1:0] o_scalar_r, o_scalar_nxt;
  logic [2:0][NormBits-1:0] o_norm_r, o_norm_nxt;
  logic o_zero_r, o_zero_nxt;
  always_comb begin
    o_scalar_nxt = '0;
    o_norm_nxt   = '0;
    o_zero_nxt   = 1'b0;
    case (op_t'(dv_out.op))
      OP_DOT:  o_scalar_nxt = ScalarBits'($signed(dv_out.sab));
      OP_SQR:  o_scalar_nxt = ScalarBits'(dv_out.saa);
      OP_LEN:  o_scalar_nxt = ScalarBits'(dv_out.len);
      OP_NORM: begin
        if (dv_out.len == '0) begin
          o_zero_nxt = 1'b1;
        end else begin
          o_norm_nxt = dv_q;
        end
      end
      default: o_scalar_nxt = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v;
    end
    if (en) begin
      o_scalar_r <= o_scalar_nxt;
      o_norm_r   <= o_norm_nxt;
      o_zero_r   <= o_zero_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, o_zero_r, o_norm_r[2], o_norm_r[1], o_norm_r[0],
                       o_scalar_r};
endmodule

@@ design/v4dmn_checker.sv @@
// ----------------------------------------------------------------------------
// v4dmn_checker: port-level checks for the vector unit
// Watches the stream ports and result encoding over time.
// ----------------------------------------------------------------------------
module v4dmn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  // A held result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed under stall");

  // Zero-length flag comes with zero components and zero scalar.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[82] |-> out_tdata[81:0] == '0)
    else $error("zero length result not clean");

  // Input is ready whenever the output stage is empty or draining.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled without output backpressure");

  // After reset no result appears at once.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind vec4_dot_magnitude_normalize v4dmn_checker u_v4dmn_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
